@@ hdl/ipc_pkg.sv @@
// shared constants and types for the inversion partition checker
package ipc_pkg;

    localparam int MAX_LEN     = 32;
    localparam int VALUE_BITS  = 16;
    localparam int TOTAL_W     = 9;
    localparam int IDX_W       = $clog2(MAX_LEN);
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int MAX_PAIRS   = (MAX_LEN * (MAX_LEN - 1)) / 2;
    localparam int PAIR_W      = $clog2(MAX_PAIRS + 1);
    localparam int WORD_W      = 64;
    localparam int REACH_WORDS = MAX_PAIRS / WORD_W + 1;
    localparam int REACH_W     = REACH_WORDS * WORD_W;
    localparam int RIDX_W      = $clog2(REACH_W);
    localparam int WS_W        = (REACH_WORDS > 1) ? $clog2(REACH_WORDS) : 1;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [PAIR_W-1:0]     t_pair;

    // controls from the sequencer to the bitset unit
    typedef struct packed {
        logic clear;
        logic step;
        logic last_word;
    } t_reach_ctl;

endpackage

@@ hdl/inversion_partition_checker_unit.sv @@
// top level of the inversion partition checker
//
// Takes one element per input beat, the last beat of a sequence marked, and
// returns one result beat per sequence: whether some subset of the
// per-element inversion counts adds up to the total inversion count, that
// total, and an overflow flag for elements dropped beyond MAX_LEN. For an
// arriving element one shared comparator walks the stored elements one per
// cycle, then the element is stored. A last beat adds the subset-sum pass,
// which goes over the 512-bit bitset once per stored element (a 64-bit
// funnel shifter takes one word a cycle), then loads the result register
// once it is free. Input stall stays high after an accepted beat until the
// unit is idle again, for a last beat through the pass and the result load.
// The result sits in an output register, so the next sequence can start
// while it waits to be taken.
module inversion_partition_checker_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ipc_pkg::VALUE_BITS-1:0] i_value,
    input  logic                           i_last,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_split_possible,
    output logic [ipc_pkg::TOTAL_W-1:0]    o_total_inversions,
    output logic                           o_overflow
);
    import ipc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_STORE,
        S_SUM,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // element storage, only written entries are ever read
    t_value r_values [MAX_LEN];
    t_idx   r_counts [MAX_LEN];

    // current beat and sequence state
    t_value r_value, n_value;
    logic   r_last, n_last;
    t_cnt   r_count, n_count;
    t_idx   r_idx, n_idx;
    t_idx   r_mine, n_mine;
    t_pair  r_pair, n_pair;
    logic   r_drop, n_drop;
    logic [WS_W-1:0] r_ws, n_ws;

    // result register
    logic               r_out_valid, n_out_valid;
    logic               r_out_split, n_out_split;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;
    logic               r_out_ovf, n_out_ovf;

    logic       w_in_acc;
    logic       w_out_take;
    logic       w_full;
    logic       w_cmp_hit;
    logic       w_idx_last;
    logic       w_ws_last;
    logic       w_hit;
    t_reach_ctl w_ctl;

    assign o_stall    = (r_state != S_IDLE);
    assign w_in_acc   = i_valid & ~o_stall;
    assign w_out_take = r_out_valid & ~i_stall;
    assign w_full     = (r_count == CNT_W'(MAX_LEN));

    // shared comparator: one stored element against the new one
    assign w_cmp_hit  = (r_values[r_idx] > r_value);
    assign w_idx_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_ws_last  = (r_ws == WS_W'(REACH_WORDS - 1));

    ipc_reach u_reach (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_shift (r_counts[r_idx]),
        .i_query (r_pair),
        .o_hit   (w_hit)
    );

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_last      = r_last;
        n_count     = r_count;
        n_idx       = r_idx;
        n_mine      = r_mine;
        n_pair      = r_pair;
        n_drop      = r_drop;
        n_ws        = r_ws;
        n_out_valid = r_out_valid;
        n_out_split = r_out_split;
        n_out_total = r_out_total;
        n_out_ovf   = r_out_ovf;
        w_ctl       = '0;

        if (w_out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_value = i_value;
                    n_last  = i_last;
                    n_idx   = '0;
                    n_mine  = '0;
                    n_ws    = '0;
                    if (!w_full) begin
                        n_state = (r_count == '0) ? S_STORE : S_CMP;
                    end else begin
                        // sequence full: drop the element, a last beat still ends it
                        n_drop  = 1'b1;
                        n_state = i_last ? S_SUM : S_IDLE;
                    end
                end
            end
            S_CMP: begin
                if (w_cmp_hit) begin
                    n_mine = r_mine + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (w_idx_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                n_pair  = r_pair + PAIR_W'(r_mine);
                n_count = r_count + 1'b1;
                n_idx   = '0;
                n_ws    = '0;
                n_state = r_last ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                // one bitset word per cycle, shifted by the current element's count
                w_ctl.step      = 1'b1;
                w_ctl.last_word = w_ws_last;
                n_ws            = r_ws + 1'b1;
                if (w_ws_last) begin
                    n_ws  = '0;
                    n_idx = r_idx + 1'b1;
                    if (w_idx_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || w_out_take) begin
                    n_out_valid = 1'b1;
                    n_out_split = w_hit;
                    n_out_total = TOTAL_W'(r_pair);
                    n_out_ovf   = r_drop;
                    // back to an empty sequence
                    w_ctl.clear = 1'b1;
                    n_count     = '0;
                    n_pair      = '0;
                    n_drop      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pair      <= '0;
            r_drop      <= 1'b0;
            r_idx       <= '0;
            r_ws        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pair      <= n_pair;
            r_drop      <= n_drop;
            r_idx       <= n_idx;
            r_ws        <= n_ws;
            r_out_valid <= n_out_valid;
        end
        r_value     <= n_value;
        r_last      <= n_last;
        r_mine      <= n_mine;
        r_out_split <= n_out_split;
        r_out_total <= n_out_total;
        r_out_ovf   <= n_out_ovf;
    end

    // element storage updates
    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP && w_cmp_hit) begin
            r_counts[r_idx] <= r_counts[r_idx] + 1'b1;
        end
        if (r_state == S_STORE) begin
            r_values[r_count[IDX_W-1:0]] <= r_value;
            r_counts[r_count[IDX_W-1:0]] <= r_mine;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_split_possible   = r_out_split;
    assign o_total_inversions = r_out_total;
    assign o_overflow         = r_out_ovf;

endmodule

@@ hdl/ipc_reach.sv @@
// reachable-sum bitset with a word-serial shift-or unit
module ipc_reach (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ipc_pkg::t_reach_ctl  i_ctl,
    input  ipc_pkg::t_idx        i_shift,
    input  ipc_pkg::t_pair       i_query,
    output logic                 o_hit
);
    import ipc_pkg::*;

    logic [REACH_W-1:0]        r_bits;
    logic [REACH_W-1:0]        n_bits;
    logic [REACH_W+WORD_W-1:0] w_ext;
    logic [WORD_W-1:0]         w_top;
    logic [WORD_W-1:0]         w_below;
    logic [WORD_W-1:0]         w_new;
    logic [2*WORD_W-1:0]       w_pair;

    // top word is worked on, then rotated to the bottom
    assign w_ext   = {r_bits, WORD_W'(0)};
    assign w_top   = r_bits[REACH_W-1 -: WORD_W];
    assign w_below = i_ctl.last_word ? '0 : w_ext[REACH_W-1 -: WORD_W];
    assign w_pair  = {w_top, w_below} << i_shift;
    assign w_new   = w_top | w_pair[2*WORD_W-1 -: WORD_W];

    always_comb begin
        n_bits = r_bits;
        if (i_ctl.clear) begin
            n_bits = REACH_W'(1);
        end else if (i_ctl.step) begin
            n_bits = (r_bits << WORD_W) | REACH_W'(w_new);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= REACH_W'(1);
        end else begin
            r_bits <= n_bits;
        end
    end

    assign o_hit = (i_query == '0) | r_bits[RIDX_W'(i_query)];

endmodule

@@ bench/partition_result_checker.sv @@
// checker that predicts and compares the inversion partition results
`timescale 1ns / 1ps
module partition_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [ipc_pkg::VALUE_BITS-1:0] i_value,
    input  logic                           i_last,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_split,
    input  logic [ipc_pkg::TOTAL_W-1:0]    i_total,
    input  logic                           i_overflow,
    output int                             o_failures,
    output int                             o_waiting
);
    import ipc_pkg::*;

    typedef struct packed {
        logic               split;
        logic [TOTAL_W-1:0] total;
        logic               dropped;
    } t_verdict;

    t_verdict expected_verdicts[$];
    t_value   seq_values[MAX_LEN];
    int       seq_counts[MAX_LEN];
    int       seq_len      = 0;
    int       seq_pairs    = 0;
    logic     seq_dropped  = 1'b0;
    int       mismatch_count = 0;
    int       waiting_count  = 0;

    assign o_failures = mismatch_count;
    assign o_waiting  = waiting_count;

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // one element into the running sequence, verdict queued on the last beat
    task automatic absorb_element(input t_value v, input logic is_last);
        int                 mine;
        logic [MAX_PAIRS:0] reach;
        t_verdict           verdict;
        mine = 0;
        if (seq_len < MAX_LEN) begin
            for (int k = 0; k < seq_len; k++) begin
                if (seq_values[k] > v) begin
                    seq_counts[k]++;
                    mine++;
                end
            end
            seq_values[seq_len] = v;
            seq_counts[seq_len] = mine;
            seq_pairs += mine;
            seq_len++;
        end else begin
            seq_dropped = 1'b1;
        end
        if (is_last) begin
            reach    = '0;
            reach[0] = 1'b1;
            for (int k = 0; k < seq_len; k++)
                reach = reach | (reach << seq_counts[k]);
            verdict.split   = (seq_pairs == 0) || reach[seq_pairs];
            verdict.total   = seq_pairs[TOTAL_W-1:0];
            verdict.dropped = seq_dropped;
            expected_verdicts.push_back(verdict);
            seq_len     = 0;
            seq_pairs   = 0;
            seq_dropped = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            seq_len     = 0;
            seq_pairs   = 0;
            seq_dropped = 1'b0;
        end else begin
            // results first: a result beat never belongs to a sequence ending this edge
            if (i_out_valid && !i_out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    flag_mismatch("result beat with no sequence pending");
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_split !== want.split)
                        flag_mismatch($sformatf("split_possible %b, want %b (total %0d)",
                                                i_split, want.split, want.total));
                    if (i_total !== want.total)
                        flag_mismatch($sformatf("total_inversions %0d, want %0d",
                                                i_total, want.total));
                    if (i_overflow !== want.dropped)
                        flag_mismatch($sformatf("overflow %b, want %b",
                                                i_overflow, want.dropped));
                end
            end
            if (i_in_valid && !i_in_stall)
                absorb_element(i_value, i_last);
        end
        waiting_count <= expected_verdicts.size();
    end

endmodule

@@ bench/testbench.sv @@
// top of the inversion partition checker testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps
module testbench;
    import ipc_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int ITEM_TARGET  = 500;
    localparam int DRAIN_CYCLES = 300;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               in_valid = 1'b0;
    t_value             in_value = '0;
    logic               in_last  = 1'b0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic               out_split;
    logic [TOTAL_W-1:0] out_total;
    logic               out_overflow;

    int failures;
    int waiting;
    int cycle_count   = 0;
    int stall_left    = 0;
    int stall_roll;
    bit steady_input  = 1'b0;
    bit steady_output = 1'b0;

    inversion_partition_checker_unit dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (in_valid),
        .o_stall            (in_stall),
        .i_value            (in_value),
        .i_last             (in_last),
        .o_valid            (out_valid),
        .i_stall            (out_stall),
        .o_split_possible   (out_split),
        .o_total_inversions (out_total),
        .o_overflow         (out_overflow)
    );

    partition_result_checker verdict_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_value     (in_value),
        .i_last      (in_last),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_split     (out_split),
        .i_total     (out_total),
        .i_overflow  (out_overflow),
        .o_failures  (failures),
        .o_waiting   (waiting)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog, and now and then a stretch where the result side never stalls
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0)
            steady_output <= ($urandom_range(0, 3) == 0);
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // result side back-pressure: mostly short stalls, a few long ones
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if (steady_output) begin
            out_stall <= 1'b0;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 60) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b1;
                stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    // idle cycles ahead of an input beat
    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_input || roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // called at a rising edge; returns at the edge that takes the beat, valid still high
    task automatic send_beat(input t_value v, input logic is_last, input int gap);
        repeat (gap) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_value <= v;
        in_last  <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic play_sequence(input t_value vals[$]);
        steady_input = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < vals.size(); k++)
            send_beat(vals[k], k == vals.size() - 1, next_gap());
    endtask

    initial begin
        t_value seq[$];
        int     len;
        int     mode;
        int     roll;
        int     items;
        bit     first;
        t_value base;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // single elements at both extremes: no pairs, empty subset answers yes
        seq = '{16'h0000};
        play_sequence(seq);
        seq = '{16'hFFFF};
        play_sequence(seq);
        // one pair, either element's count hits the total
        seq = '{16'h0005, 16'h0003};
        play_sequence(seq);
        // sorted: no inversions
        seq = '{16'h0001, 16'h0002, 16'h0003};
        play_sequence(seq);
        // reversed: counts 2,2,2 can never make 3
        seq = '{16'h0003, 16'h0002, 16'h0001};
        play_sequence(seq);
        // equal values are not inversions
        seq = '{16'h0007, 16'h0007, 16'h0007};
        play_sequence(seq);
        seq = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
        play_sequence(seq);
        seq = '{16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF};
        play_sequence(seq);

        // random sequences; the first one is a full reversed run past the length limit
        items = 0;
        first = 1'b1;
        while (items < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            mode = $urandom_range(0, 4);
            if (first) begin
                len  = MAX_LEN + 1;
                mode = 3;
            end else if (roll < 70) begin
                len = $urandom_range(1, 10);
            end else if (roll < 93) begin
                len = $urandom_range(11, MAX_LEN);
            end else begin
                len = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
            end
            first = 1'b0;
            seq.delete();
            for (int k = 0; k < len; k++) begin
                base = t_value'(k * 16 + $urandom_range(0, 15));
                case (mode)
                    0: seq.push_back(t_value'($urandom_range(0, 16'hFFFF)));
                    1: seq.push_back(t_value'($urandom_range(0, 7)));
                    2: seq.push_back(base);
                    3: seq.push_back(16'hFFFF - base);
                    default: seq.push_back($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
                endcase
            end
            play_sequence(seq);
            items += len;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
